// File: sv/gspl_pkg.sv
// shared types and constants for the grid shortest path block
// no dependencies
package gspl_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    localparam logic [1:0]  CELL_UNKNOWN = 2'd0;
    localparam logic [1:0]  CELL_WALL    = 2'd1;
    localparam logic [1:0]  CELL_FREE    = 2'd2;
    localparam logic [11:0] LEN_MAX      = 12'd4095;

    typedef enum logic [1:0] {
        ACT_FILL  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    typedef struct packed {
        t_action            action;
        logic signed [7:0]  x_coord;
        logic signed [7:0]  y_coord;
        logic [1:0]         cell_value;
        logic signed [7:0]  goal_x;
        logic signed [7:0]  goal_y;
        logic               allow_unknown;
    } t_in;

    typedef struct packed {
        logic [1:0]  read_value;
        logic        path_found;
        logic [11:0] path_length;
    } t_out;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_READ = 2'd1,
        RES_SAME = 2'd2,
        RES_HIT  = 2'd3
    } t_res;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISP, S_FILL, S_RD, S_CLR, S_SEED, S_POP, S_POPW, S_NB, S_NBW
    } t_state;

    typedef struct packed {
        logic latch;
        logic init;
        logic sweep_clr;
        logic sweep_cell;
        logic sweep_closed;
        logic cell_wr;
        logic cell_rd;
        logic seed;
        logic pop;
        logic load_cur;
        logic nb_issue;
        logic nb_mark;
        logic nb_next;
        logic finish;
        t_res res;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    q_ok;
        logic    same;
        logic    sweep_last;
        logic    q_empty;
        logic    nb_off;
        logic    nb_take;
        logic    nb_goal;
        logic    k_last;
    } t_status;

endpackage

// File: sv/grid_shortest_path_length.sv
// occupancy grid with 4-connected shortest path search
// uses gspl_pkg, gspl_ctrl, gspl_dp (which holds the gspl_ram stores)
//
// usage: drive i_item and raise start; the item is taken at an edge where start is high
// and busy is low. exactly one result per item appears on o_result for a single cycle,
// flagged by o_strobe; the receiver cannot hold it off, so it must take it then.
// busy drops in the strobe cycle, so the next item may be started at once.
// steps from acceptance to strobe:
//   write or out-of-range / trivial query: finished in the dispatch state; read: finished
//   in the read state that waits for the registered read; fill: every cell of the grid is
//   written, one cell written per cycle; query: the closed marks are cleared over the grid,
//   then each visited cell takes a queue pop and, for each of its four neighbours on the
//   grid, a read of its cell and its closed mark followed by a check of the read data
// reset: synchronous, active low; afterwards the cell store is swept to unknown,
// one cell per cycle with busy high
// distances above 4095 saturate at 4095
module grid_shortest_path_length #(
    parameter int GRID_WIDTH  = gspl_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gspl_pkg::GRID_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  gspl_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_strobe,
    output gspl_pkg::t_out o_result
);

    gspl_pkg::t_cmd    cmd;
    gspl_pkg::t_status status;

    gspl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    gspl_dp #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("result held for more than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("result while still busy");

    a_len_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.path_found) |-> (o_result.path_length == 12'd0))
        else $error("nonzero length without a path");

endmodule

// File: sv/gspl_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module gspl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/gspl_ctrl.sv
// sequencer for grid access and breadth-first search
// depends on gspl_pkg
module gspl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  gspl_pkg::t_status i_status,
    output gspl_pkg::t_cmd   o_cmd,
    output logic             busy
);

    gspl_pkg::t_state r_state, n_state;
    gspl_pkg::t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gspl_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.res = gspl_pkg::RES_ZERO;
        case (r_state)
            gspl_pkg::S_INIT: begin
                cmd.sweep_cell = 1'b1;
                cmd.init       = 1'b1;
                if (i_status.sweep_last) n_state = gspl_pkg::S_IDLE;
            end
            gspl_pkg::S_IDLE: begin
                if (start) begin
                    cmd.latch = 1'b1;
                    n_state   = gspl_pkg::S_DISP;
                end
            end
            gspl_pkg::S_DISP: begin
                case (i_status.action)
                    gspl_pkg::ACT_FILL: begin
                        cmd.sweep_clr = 1'b1;
                        n_state       = gspl_pkg::S_FILL;
                    end
                    gspl_pkg::ACT_WRITE: begin
                        cmd.cell_wr = 1'b1;
                        cmd.finish  = 1'b1;
                        n_state     = gspl_pkg::S_IDLE;
                    end
                    gspl_pkg::ACT_READ: begin
                        cmd.cell_rd = 1'b1;
                        n_state     = gspl_pkg::S_RD;
                    end
                    default: begin
                        if (!i_status.q_ok) begin
                            cmd.finish = 1'b1;
                            n_state    = gspl_pkg::S_IDLE;
                        end else if (i_status.same) begin
                            cmd.finish = 1'b1;
                            cmd.res    = gspl_pkg::RES_SAME;
                            n_state    = gspl_pkg::S_IDLE;
                        end else begin
                            cmd.sweep_clr = 1'b1;
                            n_state       = gspl_pkg::S_CLR;
                        end
                    end
                endcase
            end
            gspl_pkg::S_FILL: begin
                cmd.sweep_cell = 1'b1;
                if (i_status.sweep_last) begin
                    cmd.finish = 1'b1;
                    n_state    = gspl_pkg::S_IDLE;
                end
            end
            gspl_pkg::S_RD: begin
                cmd.finish = 1'b1;
                cmd.res    = gspl_pkg::RES_READ;
                n_state    = gspl_pkg::S_IDLE;
            end
            gspl_pkg::S_CLR: begin
                cmd.sweep_closed = 1'b1;
                if (i_status.sweep_last) n_state = gspl_pkg::S_SEED;
            end
            gspl_pkg::S_SEED: begin
                cmd.seed = 1'b1;
                n_state  = gspl_pkg::S_POP;
            end
            gspl_pkg::S_POP: begin
                if (i_status.q_empty) begin
                    cmd.finish = 1'b1;
                    n_state    = gspl_pkg::S_IDLE;
                end else begin
                    cmd.pop = 1'b1;
                    n_state = gspl_pkg::S_POPW;
                end
            end
            gspl_pkg::S_POPW: begin
                cmd.load_cur = 1'b1;
                n_state      = gspl_pkg::S_NB;
            end
            gspl_pkg::S_NB: begin
                if (i_status.nb_off) begin
                    cmd.nb_next = 1'b1;
                    if (i_status.k_last) n_state = gspl_pkg::S_POP;
                end else begin
                    cmd.nb_issue = 1'b1;
                    n_state      = gspl_pkg::S_NBW;
                end
            end
            gspl_pkg::S_NBW: begin
                cmd.nb_next = 1'b1;
                if (i_status.nb_take) cmd.nb_mark = 1'b1;
                if (i_status.nb_take && i_status.nb_goal) begin
                    cmd.finish = 1'b1;
                    cmd.res    = gspl_pkg::RES_HIT;
                    n_state    = gspl_pkg::S_IDLE;
                end else if (i_status.k_last) begin
                    n_state = gspl_pkg::S_POP;
                end else begin
                    n_state = gspl_pkg::S_NB;
                end
            end
            default: n_state = gspl_pkg::S_IDLE;
        endcase
    end

    assign o_cmd = cmd;
    assign busy  = (r_state != gspl_pkg::S_IDLE);

endmodule

// File: sv/gspl_dp.sv
// datapath: cell store, closed marks, frontier queue, neighbour walk, result register
// depends on gspl_pkg and gspl_ram
module gspl_dp #(
    parameter int GRID_WIDTH  = gspl_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = gspl_pkg::GRID_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gspl_pkg::t_in     i_item,
    input  gspl_pkg::t_cmd    i_cmd,
    output gspl_pkg::t_status o_status,
    output logic              o_strobe,
    output gspl_pkg::t_out    o_result
);

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam int N  = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW = $clog2(N);
    localparam int DW = AW;
    localparam int QW = XW + YW + DW;
    localparam int SW = (DW + 1 > 13) ? DW + 1 : 13;

    gspl_pkg::t_in  r_item;
    logic [AW-1:0]  r_cnt;
    logic [AW:0]    r_head, r_tail;
    logic [XW-1:0]  r_cx, r_nx;
    logic [YW-1:0]  r_cy, r_ny;
    logic [DW-1:0]  r_d;
    logic [1:0]     r_k;
    logic [AW-1:0]  r_naddr;
    logic           r_strobe;
    gspl_pkg::t_out r_out;

    function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
        addr_of = AW'(AW'(y) * AW'(GRID_WIDTH)) + AW'(x);
    endfunction

    function automatic logic on_grid(input logic signed [7:0] x, input logic signed [7:0] y);
        on_grid = !x[7] && !y[7] && ($unsigned(x) < 8'(GRID_WIDTH))
                  && ($unsigned(y) < 8'(GRID_HEIGHT));
    endfunction

    logic          item_ok, goal_ok;
    logic [AW-1:0] item_addr;
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic          nb_off;
    logic [1:0]    cell_rdata;
    logic          closed_rdata;
    logic [QW-1:0] q_rdata;
    logic          enter;
    logic [SW-1:0] len_sum;
    logic [11:0]   len_sat;

    assign item_ok   = on_grid(r_item.x_coord, r_item.y_coord);
    assign goal_ok   = on_grid(r_item.goal_x, r_item.goal_y);
    assign item_addr = addr_of(r_item.x_coord[XW-1:0], r_item.y_coord[YW-1:0]);

    // neighbour order: up, right, down, left
    always_comb begin
        nx     = r_cx;
        ny     = r_cy;
        nb_off = 1'b0;
        case (r_k)
            2'd0: begin
                nb_off = (r_cy == '0);
                ny     = r_cy - YW'(1);
            end
            2'd1: begin
                nb_off = (r_cx == XW'(GRID_WIDTH - 1));
                nx     = r_cx + XW'(1);
            end
            2'd2: begin
                nb_off = (r_cy == YW'(GRID_HEIGHT - 1));
                ny     = r_cy + YW'(1);
            end
            default: begin
                nb_off = (r_cx == '0);
                nx     = r_cx - XW'(1);
            end
        endcase
    end

    // cell store
    logic          cell_we;
    logic [AW-1:0] cell_waddr, cell_raddr;
    logic [1:0]    cell_wdata;

    assign cell_we    = i_cmd.sweep_cell || (i_cmd.cell_wr && item_ok);
    assign cell_waddr = i_cmd.sweep_cell ? r_cnt : item_addr;
    assign cell_wdata = i_cmd.init ? gspl_pkg::CELL_UNKNOWN : r_item.cell_value;
    assign cell_raddr = i_cmd.cell_rd ? item_addr : addr_of(nx, ny);

    gspl_ram #(.WIDTH(2), .DEPTH(N)) u_cell (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    // closed marks
    logic          cl_we;
    logic [AW-1:0] cl_waddr;

    assign cl_we    = i_cmd.sweep_closed || i_cmd.seed || i_cmd.nb_mark;
    assign cl_waddr = i_cmd.sweep_closed ? r_cnt : (i_cmd.seed ? item_addr : r_naddr);

    gspl_ram #(.WIDTH(1), .DEPTH(N)) u_closed (
        .i_clk   (i_clk),
        .i_we    (cl_we),
        .i_waddr (cl_waddr),
        .i_wdata (!i_cmd.sweep_closed),
        .i_raddr (addr_of(nx, ny)),
        .o_rdata (closed_rdata)
    );

    // frontier queue holds column, row and distance of each cell
    logic          q_we;
    logic [QW-1:0] q_wdata;

    assign q_we    = i_cmd.seed || i_cmd.nb_mark;
    assign q_wdata = i_cmd.seed
                     ? {r_item.x_coord[XW-1:0], r_item.y_coord[YW-1:0], {DW{1'b0}}}
                     : {r_nx, r_ny, r_d + DW'(1)};

    gspl_ram #(.WIDTH(QW), .DEPTH(N)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (i_cmd.seed ? {AW{1'b0}} : r_tail[AW-1:0]),
        .i_wdata (q_wdata),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (q_rdata)
    );

    always_comb begin
        case (cell_rdata)
            gspl_pkg::CELL_WALL: enter = 1'b0;
            gspl_pkg::CELL_FREE: enter = 1'b1;
            default:             enter = r_item.allow_unknown;
        endcase
    end

    assign len_sum = SW'(r_d) + SW'(1);
    assign len_sat = (len_sum > SW'(gspl_pkg::LEN_MAX)) ? gspl_pkg::LEN_MAX : len_sum[11:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_item <= i_item;
        if (i_cmd.load_cur) begin
            {r_cx, r_cy, r_d} <= q_rdata;
        end
        if (i_cmd.nb_issue) begin
            r_nx    <= nx;
            r_ny    <= ny;
            r_naddr <= addr_of(nx, ny);
        end
        case (i_cmd.res)
            gspl_pkg::RES_READ: r_out <= '{read_value: item_ok ? cell_rdata
                                                               : gspl_pkg::CELL_WALL,
                                           path_found: 1'b0, path_length: 12'd0};
            gspl_pkg::RES_SAME: r_out <= '{read_value: 2'd0, path_found: 1'b1,
                                           path_length: 12'd0};
            gspl_pkg::RES_HIT:  r_out <= '{read_value: 2'd0, path_found: 1'b1,
                                           path_length: len_sat};
            default:            r_out <= '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_k      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
            if (i_cmd.sweep_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.sweep_cell || i_cmd.sweep_closed) begin
                r_cnt <= r_cnt + AW'(1);
            end
            if (i_cmd.seed) begin
                r_head <= '0;
                r_tail <= (AW + 1)'(1);
            end else begin
                if (i_cmd.pop)     r_head <= r_head + (AW + 1)'(1);
                if (i_cmd.nb_mark) r_tail <= r_tail + (AW + 1)'(1);
            end
            if (i_cmd.load_cur) begin
                r_k <= '0;
            end else if (i_cmd.nb_next) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    assign o_status.action     = r_item.action;
    assign o_status.q_ok       = item_ok && goal_ok;
    assign o_status.same       = (r_item.x_coord == r_item.goal_x)
                                 && (r_item.y_coord == r_item.goal_y);
    assign o_status.sweep_last = (r_cnt == AW'(N - 1));
    assign o_status.q_empty    = (r_head == r_tail);
    assign o_status.nb_off     = nb_off;
    assign o_status.nb_take    = !closed_rdata && enter;
    assign o_status.nb_goal    = (8'(r_nx) == r_item.goal_x) && (8'(r_ny) == r_item.goal_y);
    assign o_status.k_last     = (r_k == 2'd3);

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// File: dv/grid_shortest_path_length_tb.sv
// testbench for grid_shortest_path_length: directed table then random items,
// each result checked against a behavioural grid and breadth-first search model
// depends on gspl_pkg and the grid_shortest_path_length rtl
`timescale 1ns / 1ps

module grid_shortest_path_length_tb;

    localparam int GW = 64;
    localparam int GH = 64;
    localparam int CELLS = GW * GH;
    localparam int N_DIR = 20;
    localparam int N_RAND = 80;
    localparam longint CYCLE_LIMIT = 64'd20_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    gspl_pkg::t_in i_item = '0;
    logic busy;
    logic o_strobe;
    gspl_pkg::t_out o_result;

    grid_shortest_path_length #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_strobe(o_strobe), .o_result(o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [1:0]     grid_cells [CELLS];
    logic           seen_cells [CELLS];
    int             hop_count  [CELLS];
    int             bfs_queue  [CELLS];
    gspl_pkg::t_out pending_results [$];
    int             fail_count = 0;
    longint         cycle_count = 0;

    function automatic logic in_grid(logic signed [7:0] x, logic signed [7:0] y);
        return x >= 0 && x < GW && y >= 0 && y < GH;
    endfunction

    function automatic logic can_enter(logic [1:0] c, logic unk);
        if (c == gspl_pkg::CELL_WALL) return 1'b0;
        if (c == gspl_pkg::CELL_FREE) return 1'b1;
        return unk;
    endfunction

    function automatic gspl_pkg::t_out predict_item(gspl_pkg::t_in it);
        gspl_pkg::t_out r;
        int s, g, head, tail, cur, nx, ny, n, k;
        int dx [4];
        int dy [4];
        r = '0;
        dx = '{0, 1, 0, -1};
        dy = '{-1, 0, 1, 0};
        case (it.action)
            gspl_pkg::ACT_FILL: for (int i = 0; i < CELLS; i++) grid_cells[i] = it.cell_value;
            gspl_pkg::ACT_WRITE: if (in_grid(it.x_coord, it.y_coord))
                grid_cells[int'(it.y_coord) * GW + int'(it.x_coord)] = it.cell_value;
            gspl_pkg::ACT_READ: r.read_value = in_grid(it.x_coord, it.y_coord) ?
                grid_cells[int'(it.y_coord) * GW + int'(it.x_coord)] : gspl_pkg::CELL_WALL;
            default: if (in_grid(it.x_coord, it.y_coord) && in_grid(it.goal_x, it.goal_y)) begin
                s = int'(it.y_coord) * GW + int'(it.x_coord);
                g = int'(it.goal_y) * GW + int'(it.goal_x);
                if (s == g) begin
                    r.path_found = 1'b1;
                    return r;
                end
                for (int i = 0; i < CELLS; i++) seen_cells[i] = 1'b0;
                head = 0;
                tail = 1;
                bfs_queue[0] = s;
                seen_cells[s] = 1'b1;
                hop_count[s] = 0;
                while (head < tail) begin
                    cur = bfs_queue[head];
                    head++;
                    for (k = 0; k < 4; k++) begin
                        nx = cur % GW + dx[k];
                        ny = cur / GW + dy[k];
                        if (nx < 0 || nx >= GW || ny < 0 || ny >= GH) continue;
                        n = ny * GW + nx;
                        if (seen_cells[n] || !can_enter(grid_cells[n], it.allow_unknown))
                            continue;
                        seen_cells[n] = 1'b1;
                        hop_count[n] = hop_count[cur] + 1;
                        if (n == g) begin
                            r.path_found = 1'b1;
                            r.path_length = hop_count[n] > 4095 ? gspl_pkg::LEN_MAX
                                                                : 12'(hop_count[n]);
                            return r;
                        end
                        bfs_queue[tail] = n;
                        tail++;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // results are taken in the cycle the strobe is high
    always @(posedge i_clk) begin
        gspl_pkg::t_out want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: %h", o_result);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.read_value !== want.read_value) begin
                    $error("read_value exp %0d got %0d", want.read_value, o_result.read_value);
                    fail_count++;
                end
                if (o_result.path_found !== want.path_found) begin
                    $error("path_found exp %0d got %0d", want.path_found, o_result.path_found);
                    fail_count++;
                end
                if (o_result.path_length !== want.path_length) begin
                    $error("path_length exp %0d got %0d", want.path_length,
                           o_result.path_length);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic gspl_pkg::t_in make_item(gspl_pkg::t_action a, int x, int y,
                                                logic [1:0] v, int gx, int gy, logic unk);
        gspl_pkg::t_in it;
        it.action = a;
        it.x_coord = 8'(x);
        it.y_coord = 8'(y);
        it.cell_value = v;
        it.goal_x = 8'(gx);
        it.goal_y = 8'(gy);
        it.allow_unknown = unk;
        return it;
    endfunction

    // hand one item over; start stays high across back-to-back items
    task automatic send_item(gspl_pkg::t_in it, int idle_pct, logic fixed_ok,
                             gspl_pkg::t_out fixed_res);
        gspl_pkg::t_out want;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        want = predict_item(it);
        if (fixed_ok && want !== fixed_res) begin
            $error("table row exp %h predictor %h", fixed_res, want);
            fail_count++;
        end
        start <= 1'b1;
        i_item <= it;
        pending_results.insert(pending_results.size(), want);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // random cell biased to the grid, sometimes far outside it
    function automatic int pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 8) return $urandom_range(255) - 128;
        if (r < 12) return (r & 1) ? -1 : GW;
        if (r < 50) return $urandom_range(7);
        return $urandom_range(GW - 1);
    endfunction

    typedef struct {
        gspl_pkg::t_in  it;
        logic           fixed_ok;
        gspl_pkg::t_out fixed_res;
    } t_row;

    t_row stim_table [N_DIR];

    initial begin
        gspl_pkg::t_in it;
        int idle_pct, r;
        gspl_pkg::t_out z;
        z = '0;
        stim_table = '{
            '{make_item(gspl_pkg::ACT_READ, 0, 0, 2'd0, 0, 0, 1'b0), 1'b1,
              gspl_pkg::t_out'{2'd0, 1'b0, 12'd0}},
            '{make_item(gspl_pkg::ACT_READ, -128, 127, 2'd3, -1, 64, 1'b1), 1'b1,
              gspl_pkg::t_out'{gspl_pkg::CELL_WALL, 1'b0, 12'd0}},
            '{make_item(gspl_pkg::ACT_WRITE, 63, 63, 2'd3, 0, 0, 1'b0), 1'b1, z},
            '{make_item(gspl_pkg::ACT_READ, 63, 63, 2'd0, 0, 0, 1'b0), 1'b1,
              gspl_pkg::t_out'{2'd3, 1'b0, 12'd0}},
            '{make_item(gspl_pkg::ACT_WRITE, 64, 0, 2'd1, 0, 0, 1'b0), 1'b1, z},
            '{make_item(gspl_pkg::ACT_WRITE, 127, -128, 2'd2, 0, 0, 1'b1), 1'b1, z},
            '{make_item(gspl_pkg::ACT_QUERY, 5, 5, 2'd0, 5, 5, 1'b0), 1'b1,
              gspl_pkg::t_out'{2'd0, 1'b1, 12'd0}},
            '{make_item(gspl_pkg::ACT_QUERY, -1, 0, 2'd0, 3, 3, 1'b1), 1'b1, z},
            '{make_item(gspl_pkg::ACT_QUERY, 0, 0, 2'd0, 3, 64, 1'b1), 1'b1, z},
            '{make_item(gspl_pkg::ACT_QUERY, 0, 0, 2'd0, 63, 63, 1'b0), 1'b1, z},
            '{make_item(gspl_pkg::ACT_QUERY, 0, 0, 2'd0, 63, 63, 1'b1), 1'b1,
              gspl_pkg::t_out'{2'd0, 1'b1, 12'd126}},
            '{make_item(gspl_pkg::ACT_FILL, 0, 0, gspl_pkg::CELL_FREE, 0, 0, 1'b0), 1'b1, z},
            '{make_item(gspl_pkg::ACT_QUERY, 63, 0, 2'd0, 0, 63, 1'b0), 1'b1,
              gspl_pkg::t_out'{2'd0, 1'b1, 12'd126}},
            '{make_item(gspl_pkg::ACT_WRITE, 1, 0, gspl_pkg::CELL_WALL, 0, 0, 1'b0), 1'b0, z},
            '{make_item(gspl_pkg::ACT_WRITE, 0, 1, gspl_pkg::CELL_WALL, 0, 0, 1'b0), 1'b0, z},
            '{make_item(gspl_pkg::ACT_QUERY, 0, 0, 2'd0, 9, 9, 1'b1), 1'b1, z},
            '{make_item(gspl_pkg::ACT_QUERY, 9, 9, 2'd0, 0, 2, 1'b0), 1'b0, z},
            '{make_item(gspl_pkg::ACT_FILL, 0, 0, gspl_pkg::CELL_WALL, 0, 0, 1'b0), 1'b1, z},
            '{make_item(gspl_pkg::ACT_QUERY, 2, 2, 2'd0, 2, 3, 1'b1), 1'b1, z},
            '{make_item(gspl_pkg::ACT_FILL, 0, 0, gspl_pkg::CELL_UNKNOWN, 0, 0, 1'b0), 1'b1, z}
        };
        for (int i = 0; i < CELLS; i++) grid_cells[i] = gspl_pkg::CELL_UNKNOWN;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        for (int i = 0; i < N_DIR; i++)
            send_item(stim_table[i].it, 10, stim_table[i].fixed_ok, stim_table[i].fixed_res);
        for (int n = 0; n < N_RAND; n++) begin
            idle_pct = n < 27 ? 27 : (n < 54 ? 81 : 0);
            if (n == 50) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            r = $urandom_range(99);
            it.x_coord = 8'(pick_coord());
            it.y_coord = 8'(pick_coord());
            it.goal_x = 8'(pick_coord());
            it.goal_y = 8'(pick_coord());
            it.cell_value = 2'($urandom_range(3));
            it.allow_unknown = 1'($urandom_range(1));
            // mostly free or wall writes so queries meet real mazes
            if (r < 3) begin
                it.action = gspl_pkg::ACT_FILL;
                it.cell_value = $urandom_range(1) ? gspl_pkg::CELL_FREE
                                                  : 2'($urandom_range(3));
            end else if (r < 55) begin
                it.action = gspl_pkg::ACT_WRITE;
                if ($urandom_range(3) != 0) it.cell_value = gspl_pkg::CELL_WALL;
            end else if (r < 70) it.action = gspl_pkg::ACT_READ;
            else it.action = gspl_pkg::ACT_QUERY;
            send_item(it, idle_pct, 1'b0, z);
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: grid_shortest_path_length.f
sv/gspl_pkg.sv
sv/gspl_ram.sv
sv/gspl_ctrl.sv
sv/gspl_dp.sv
sv/grid_shortest_path_length.sv
dv/grid_shortest_path_length_tb.sv
